@@ src/bvm_pkg.sv @@
// Shared constants for the battery voltage monitor: field widths, register
// indexes, saturation limits and configuration defaults.
// No dependencies.
package bvm_pkg;

    localparam int REF_W    = 11;
    localparam int CODE_W   = 10;
    localparam int COIL_W   = 14;
    localparam int MV_W     = 15;
    localparam int MW_W     = 24;
    localparam int FS_W     = 16;
    localparam int Q10_W    = 10;
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;

    localparam int ADC_FULL_SCALE_DEF    = 1023;
    localparam int FILTER_WEIGHT_Q10_DEF = 41;

    // ref * full scale fits 27 bits; times a battery code it fits 37 bits
    localparam int RAW_W    = REF_W + FS_W;
    localparam int DIV_N_W  = RAW_W + CODE_W;
    localparam int DIV_D_W  = FS_W;
    localparam int MUL_A_W  = RAW_W;
    localparam int MUL_B_W  = FS_W;
    localparam int MUL_P_W  = MUL_A_W + MUL_B_W;

    localparam logic [MV_W-1:0] MV_MAX = {MV_W{1'b1}};
    localparam logic [MW_W-1:0] MW_MAX = {MW_W{1'b1}};

    localparam logic [REF_W-1:0]  REF_MV_RST = REF_W'(1100);
    localparam logic [COIL_W-1:0] COIL_RST   = COIL_W'(200);

    localparam logic [1:0] REG_REF_MV  = 2'd0;
    localparam logic [1:0] REG_BOOSTER = 2'd1;
    localparam logic [1:0] REG_COIL    = 2'd2;

endpackage

@@ src/battery_voltage_monitor_core.sv @@
// Battery voltage monitor: supply millivolts from a bandgap conversion, optional
// booster scaling, Q10 low-pass filter and maximum power into the coil load.
// Depends on bvm_pkg and bvm_divider.
//
// One beat at a time: after s_ready falls the block works through a small
// sequencer around one shared multiplier and one shared bit-serial divider, and
// raises s_ready again once the result sits in the output register. An initialize
// beat skips the old-value filter step, and booster mode adds a multiply step and a
// third division. A zero bandgap code skips the reference division, any booster step
// and the saturation step; zero coil resistance skips the power division. Results
// are held in an output register, so a stalled m_ready delays only the next beat.
// Configuration writes take effect at once and are meant for idle time.
module battery_voltage_monitor_core #(
    parameter int ADC_FULL_SCALE    = bvm_pkg::ADC_FULL_SCALE_DEF,
    parameter int FILTER_WEIGHT_Q10 = bvm_pkg::FILTER_WEIGHT_Q10_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bvm_pkg::ADDR_W-1:0]   paddr,
    input  logic [bvm_pkg::DATA_W-1:0]   pwdata,
    output logic [bvm_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_command,
    input  logic [bvm_pkg::CODE_W-1:0]   s_bandgap_code,
    input  logic [bvm_pkg::CODE_W-1:0]   s_battery_code,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [bvm_pkg::MV_W-1:0]     m_battery_mv,
    output logic [bvm_pkg::MW_W-1:0]     m_max_power_mw,
    output logic                         m_range_error
);
    import bvm_pkg::*;

    localparam logic [FS_W-1:0]  FULL_SCALE = FS_W'(ADC_FULL_SCALE);
    localparam logic [Q10_W-1:0] WEIGHT_NEW = Q10_W'(FILTER_WEIGHT_Q10);
    localparam logic [Q10_W-1:0] WEIGHT_OLD = Q10_W'(1024 - FILTER_WEIGHT_Q10);

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_MUL_REF  = 4'd1;
    localparam logic [3:0] ST_DIV_REF  = 4'd2;
    localparam logic [3:0] ST_WAIT_REF = 4'd3;
    localparam logic [3:0] ST_MUL_BAT  = 4'd4;
    localparam logic [3:0] ST_DIV_BAT  = 4'd5;
    localparam logic [3:0] ST_WAIT_BAT = 4'd6;
    localparam logic [3:0] ST_SAT      = 4'd7;
    localparam logic [3:0] ST_FLT_NEW  = 4'd8;
    localparam logic [3:0] ST_FLT_OLD  = 4'd9;
    localparam logic [3:0] ST_MUL_PWR  = 4'd10;
    localparam logic [3:0] ST_DIV_PWR  = 4'd11;
    localparam logic [3:0] ST_WAIT_PWR = 4'd12;
    localparam logic [3:0] ST_DONE     = 4'd13;

    logic [REF_W-1:0]  ref_mv_reg;
    logic              booster_reg;
    logic [COIL_W-1:0] coil_reg;
    logic              cfg_write;

    logic [3:0]        state_reg, state_next;
    logic              cmd_reg, cmd_next;
    logic [CODE_W-1:0] code_reg, code_next;
    logic [CODE_W-1:0] batt_reg, batt_next;
    logic [MV_W-1:0]   raw_reg, raw_next;
    logic [MV_W-1:0]   filt_reg, filt_next;
    logic [MW_W-1:0]   pwr_reg, pwr_next;
    logic              err_reg, err_next;
    logic [MUL_P_W-1:0] prod_reg, prod_next;

    logic              m_valid_reg, m_valid_next;
    logic [MV_W-1:0]   m_mv_reg, m_mv_next;
    logic [MW_W-1:0]   m_mw_reg, m_mw_next;
    logic              m_err_reg, m_err_next;

    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic               mul_acc;
    logic [MUL_P_W-1:0] mul_out;

    logic               div_start;
    logic [DIV_D_W-1:0] div_divisor;
    logic               div_done;
    logic [DIV_N_W-1:0] div_quo;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ref_mv_reg  <= REF_MV_RST;
            booster_reg <= 1'b0;
            coil_reg    <= COIL_RST;
        end else if (cfg_write) begin
            unique case (paddr[3:2])
                REG_REF_MV:  ref_mv_reg  <= pwdata[REF_W-1:0];
                REG_BOOSTER: booster_reg <= pwdata[0];
                REG_COIL:    coil_reg    <= pwdata[COIL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_REF_MV:  prdata = DATA_W'(ref_mv_reg);
            REG_BOOSTER: prdata = DATA_W'(booster_reg);
            REG_COIL:    prdata = DATA_W'(coil_reg);
            default:     prdata = '0;
        endcase
    end

    // shared multiplier operand select
    always_comb begin
        mul_a   = '0;
        mul_b   = '0;
        mul_acc = 1'b0;
        unique case (state_reg)
            ST_MUL_REF: begin
                mul_a = MUL_A_W'(ref_mv_reg);
                mul_b = FULL_SCALE;
            end
            ST_MUL_BAT: begin
                mul_a = div_quo[MUL_A_W-1:0];
                mul_b = MUL_B_W'(batt_reg);
            end
            ST_FLT_NEW: begin
                mul_a = MUL_A_W'(raw_reg);
                mul_b = MUL_B_W'(WEIGHT_NEW);
            end
            ST_FLT_OLD: begin
                mul_a   = MUL_A_W'(filt_reg);
                mul_b   = MUL_B_W'(WEIGHT_OLD);
                mul_acc = 1'b1;
            end
            ST_MUL_PWR: begin
                mul_a = MUL_A_W'(filt_reg);
                mul_b = MUL_B_W'(filt_reg);
            end
            default: ;
        endcase
    end

    assign mul_out   = mul_a * mul_b;
    assign prod_next = mul_acc ? (prod_reg + mul_out) : mul_out;

    // shared divider operand select
    always_comb begin
        div_start   = 1'b0;
        div_divisor = '0;
        unique case (state_reg)
            ST_DIV_REF: begin
                div_start   = 1'b1;
                div_divisor = DIV_D_W'(code_reg);
            end
            ST_DIV_BAT: begin
                div_start   = 1'b1;
                div_divisor = FULL_SCALE;
            end
            ST_DIV_PWR: begin
                div_start   = 1'b1;
                div_divisor = DIV_D_W'(coil_reg);
            end
            default: ;
        endcase
    end

    bvm_divider #(
        .N_W(DIV_N_W),
        .D_W(DIV_D_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (prod_reg[DIV_N_W-1:0]),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    // sequencer
    always_comb begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        code_next    = code_reg;
        batt_next    = batt_reg;
        raw_next     = raw_reg;
        filt_next    = filt_reg;
        pwr_next     = pwr_reg;
        err_next     = err_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_mv_next    = m_mv_reg;
        m_mw_next    = m_mw_reg;
        m_err_next   = m_err_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd_next   = s_command;
                    code_next  = s_bandgap_code;
                    batt_next  = s_battery_code;
                    err_next   = 1'b0;
                    state_next = ST_MUL_REF;
                end
            end
            ST_MUL_REF: begin
                if (code_reg == '0) begin
                    raw_next   = MV_MAX;
                    err_next   = 1'b1;
                    state_next = ST_FLT_NEW;
                end else begin
                    state_next = ST_DIV_REF;
                end
            end
            ST_DIV_REF: state_next = ST_WAIT_REF;
            ST_WAIT_REF: begin
                if (div_done) begin
                    state_next = booster_reg ? ST_MUL_BAT : ST_SAT;
                end
            end
            ST_MUL_BAT: state_next = ST_DIV_BAT;
            ST_DIV_BAT: state_next = ST_WAIT_BAT;
            ST_WAIT_BAT: begin
                if (div_done) begin
                    state_next = ST_SAT;
                end
            end
            ST_SAT: begin
                if (div_quo > DIV_N_W'(MV_MAX)) begin
                    raw_next = MV_MAX;
                    err_next = 1'b1;
                end else begin
                    raw_next = div_quo[MV_W-1:0];
                end
                state_next = ST_FLT_NEW;
            end
            ST_FLT_NEW: begin
                if (!cmd_reg) begin
                    filt_next  = raw_reg;
                    state_next = ST_MUL_PWR;
                end else begin
                    state_next = ST_FLT_OLD;
                end
            end
            ST_FLT_OLD: begin
                filt_next  = prod_next[Q10_W +: MV_W];
                state_next = ST_MUL_PWR;
            end
            ST_MUL_PWR: begin
                if (coil_reg == '0) begin
                    pwr_next   = MW_MAX;
                    err_next   = 1'b1;
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_DIV_PWR;
                end
            end
            ST_DIV_PWR: state_next = ST_WAIT_PWR;
            ST_WAIT_PWR: begin
                if (div_done) begin
                    if (div_quo > DIV_N_W'(MW_MAX)) begin
                        pwr_next = MW_MAX;
                        err_next = 1'b1;
                    end else begin
                        pwr_next = div_quo[MW_W-1:0];
                    end
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_mv_next    = filt_reg;
                    m_mw_next    = pwr_reg;
                    m_err_next   = err_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        cmd_reg   <= cmd_next;
        code_reg  <= code_next;
        batt_reg  <= batt_next;
        raw_reg   <= raw_next;
        pwr_reg   <= pwr_next;
        err_reg   <= err_next;
        prod_reg  <= prod_next;
        m_mv_reg  <= m_mv_next;
        m_mw_reg  <= m_mw_next;
        m_err_reg <= m_err_next;
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            filt_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            filt_reg    <= filt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_battery_mv   = m_mv_reg;
    assign m_max_power_mw = m_mw_reg;
    assign m_range_error  = m_err_reg;

endmodule

@@ src/bvm_divider.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on bvm_pkg for default widths.
module bvm_divider #(
    parameter int N_W = bvm_pkg::DIV_N_W,
    parameter int D_W = bvm_pkg::DIV_D_W
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           start,
    input  logic [N_W-1:0] dividend,
    input  logic [D_W-1:0] divisor,
    output logic           done,
    output logic [N_W-1:0] quotient
);
    import bvm_pkg::*;

    localparam int CNT_W = $clog2(N_W + 1);

    logic [D_W:0]   rem_reg, rem_next;
    logic [N_W-1:0] quo_reg, quo_next;
    logic [D_W-1:0] dsr_reg, dsr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic           done_reg, done_next;
    logic [D_W:0]   shifted;
    logic           fits;

    assign shifted = {rem_reg[D_W-1:0], quo_reg[N_W-1]};
    assign fits    = shifted >= {1'b0, dsr_reg};

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next = '0;
            quo_next = dividend;
            dsr_next = divisor;
            cnt_next = CNT_W'(N_W);
        end else if (cnt_reg != '0) begin
            rem_next  = fits ? (shifted - {1'b0, dsr_reg}) : shifted;
            quo_next  = {quo_reg[N_W-2:0], fits};
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ verif/tb_battery_voltage_monitor_core.sv @@
// Self-checking testbench for battery_voltage_monitor_core: APB register setup,
// valid/ready sample beats checked against an in-bench filter and power predictor.
// Depends on bvm_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_battery_voltage_monitor_core;
    import bvm_pkg::*;

    localparam int ADC_FS       = ADC_FULL_SCALE_DEF;
    localparam int FILT_WT      = FILTER_WEIGHT_Q10_DEF;
    localparam int PHASES       = 7;
    localparam int RAND_PER_PH  = 256;
    localparam int SETTLE_CYC   = 150;

    typedef struct packed {
        logic              cmd;
        logic [CODE_W-1:0] bg;
        logic [CODE_W-1:0] batt;
    } sample_t;

    typedef struct packed {
        logic [MV_W-1:0] mv;
        logic [MW_W-1:0] mw;
        logic            err;
    } reading_t;

    logic                 aclk;
    logic                 aresetn        = 1'b0;
    logic                 psel           = 1'b0;
    logic                 penable        = 1'b0;
    logic                 pwrite         = 1'b0;
    logic [ADDR_W-1:0]    paddr          = '0;
    logic [DATA_W-1:0]    pwdata         = '0;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;
    logic                 s_valid        = 1'b0;
    logic                 s_ready;
    logic                 s_command      = 1'b0;
    logic [CODE_W-1:0]    s_bandgap_code = '0;
    logic [CODE_W-1:0]    s_battery_code = '0;
    logic                 m_valid;
    logic                 m_ready        = 1'b0;
    logic [MV_W-1:0]      m_battery_mv;
    logic [MW_W-1:0]      m_max_power_mw;
    logic                 m_range_error;

    logic [REF_W-1:0]     ref_mv_cfg  = REF_MV_RST;
    logic                 booster_cfg = 1'b0;
    logic [COIL_W-1:0]    coil_cfg    = COIL_RST;
    logic [MV_W-1:0]      filt_mv     = '0;

    sample_t              pending_q[$];
    reading_t             reading_q[$];
    sample_t              cur_sample;
    int                   send_idle_pct = 0;
    int                   recv_idle_pct = 0;
    int                   queued_total  = 0;
    int                   done_total    = 0;
    int                   fail_cnt      = 0;
    int                   init_beats    = 0;
    int                   err_beats     = 0;

    battery_voltage_monitor_core uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_bandgap_code (s_bandgap_code),
        .s_battery_code (s_battery_code),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_battery_mv   (m_battery_mv),
        .m_max_power_mw (m_max_power_mw),
        .m_range_error  (m_range_error)
    );

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    function automatic reading_t predict_reading(sample_t smp);
        logic [63:0] raw;
        logic [63:0] acc;
        logic [63:0] pw;
        reading_t    rd;
        rd.err = 1'b0;
        if (smp.bg == '0) begin
            raw    = 64'(MV_MAX);
            rd.err = 1'b1;
        end else begin
            raw = (64'(ref_mv_cfg) * 64'(ADC_FS)) / 64'(smp.bg);
            if (booster_cfg)
                raw = (raw * 64'(smp.batt)) / 64'(ADC_FS);
            if (raw > 64'(MV_MAX)) begin
                raw    = 64'(MV_MAX);
                rd.err = 1'b1;
            end
        end
        if (!smp.cmd) begin
            filt_mv = raw[MV_W-1:0];
        end else begin
            acc     = 64'(FILT_WT) * raw + 64'(1024 - FILT_WT) * 64'(filt_mv);
            filt_mv = acc[10 +: MV_W];
        end
        if (coil_cfg == '0) begin
            pw     = 64'(MW_MAX);
            rd.err = 1'b1;
        end else begin
            pw = (64'(filt_mv) * 64'(filt_mv)) / 64'(coil_cfg);
            if (pw > 64'(MW_MAX)) begin
                pw     = 64'(MW_MAX);
                rd.err = 1'b1;
            end
        end
        rd.mv = filt_mv;
        rd.mw = pw[MW_W-1:0];
        return rd;
    endfunction

    task automatic push_sample(input logic cmd, input int bg, input int batt);
        sample_t smp;
        smp.cmd  = cmd;
        smp.bg   = CODE_W'(bg);
        smp.batt = CODE_W'(batt);
        pending_q.push_back(smp);
        queued_total++;
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [DATA_W-1:0] val);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_REF_MV:  ref_mv_cfg  = val[REF_W-1:0];
            REG_BOOSTER: booster_cfg = val[0];
            REG_COIL:    coil_cfg    = val[COIL_W-1:0];
            default:     ;
        endcase
    endtask

    // sample driver: predict on each accepted beat, then load the next one
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                reading_q.push_back(predict_reading(cur_sample));
                if (!cur_sample.cmd)
                    init_beats++;
            end
            if (!s_valid || s_ready) begin
                if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    cur_sample = pending_q.pop_front();
                    s_valid        <= 1'b1;
                    s_command      <= cur_sample.cmd;
                    s_bandgap_code <= cur_sample.bg;
                    s_battery_code <= cur_sample.batt;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        reading_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (reading_q.size() == 0) begin
                    $error("unexpected result beat: battery_mv %0d", m_battery_mv);
                    fail_cnt++;
                end else begin
                    want = reading_q.pop_front();
                    if (m_battery_mv !== want.mv) begin
                        $error("battery_mv: expected %0d, actual %0d", want.mv, m_battery_mv);
                        fail_cnt++;
                    end
                    if (m_max_power_mw !== want.mw) begin
                        $error("max_power_mw: expected %0d, actual %0d",
                               want.mw, m_max_power_mw);
                        fail_cnt++;
                    end
                    if (m_range_error !== want.err) begin
                        $error("range_error: expected %0d, actual %0d",
                               want.err, m_range_error);
                        fail_cnt++;
                    end
                    if (want.err)
                        err_beats++;
                    done_total++;
                end
            end
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin
        int ref_tbl[PHASES];
        int boost_tbl[PHASES];
        int coil_tbl[PHASES];
        int snd_tbl[PHASES];
        int rcv_tbl[PHASES];
        int bg;
        int batt;
        int pick;
        ref_tbl   = '{1100, 900, 1400, 2047, 0, 1100, 1400};
        boost_tbl = '{0, 1, 0, 1, 0, 0, 1};
        coil_tbl  = '{200, 1, 10000, 0, 16383, 200, 200};
        snd_tbl   = '{29, 29, 29, 72, 72, 0, 0};
        rcv_tbl   = '{72, 72, 72, 29, 29, 0, 0};
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        for (int ph = 0; ph < PHASES; ph++) begin
            while (done_total != queued_total)
                @(posedge aclk);
            repeat (8) @(posedge aclk);
            if (ph == 5) begin
                ref_tbl[ph]   = $urandom_range(1400, 900);
                boost_tbl[ph] = $urandom_range(1);
                coil_tbl[ph]  = $urandom_range(10000, 1);
            end
            apb_write(REG_REF_MV, DATA_W'(ref_tbl[ph]));
            apb_write(REG_BOOSTER, DATA_W'(boost_tbl[ph]));
            apb_write(REG_COIL, DATA_W'(coil_tbl[ph]));
            send_idle_pct = snd_tbl[ph];
            recv_idle_pct = rcv_tbl[ph];
            if (ph == 0) begin
                push_sample(1'b0, 0, 0);
                push_sample(1'b1, 0, 1023);
                push_sample(1'b0, 1, 0);
                push_sample(1'b0, 1023, 1023);
                push_sample(1'b1, 341, 0);
                push_sample(1'b1, 341, 512);
                push_sample(1'b0, 341, 0);
                push_sample(1'b1, 256, 0);
                push_sample(1'b1, 512, 1023);
                push_sample(1'b1, 37, 0);
                push_sample(1'b1, 34, 0);
                push_sample(1'b0, 35, 0);
                push_sample(1'b1, 1023, 0);
                push_sample(1'b0, 682, 341);
                push_sample(1'b1, 5, 1023);
            end else if (ph == 1) begin
                push_sample(1'b0, 1023, 1023);
                push_sample(1'b1, 1023, 0);
                push_sample(1'b0, 100, 1023);
                push_sample(1'b0, 1, 1);
                push_sample(1'b0, 1, 1023);
                push_sample(1'b1, 0, 1023);
            end
            for (int n = 0; n < RAND_PER_PH; n++) begin
                pick = $urandom_range(99);
                if (pick < 70)
                    bg = $urandom_range(450, 180);
                else if (pick < 95)
                    bg = $urandom_range(1023);
                else if (pick < 98)
                    bg = 0;
                else
                    bg = $urandom_range(1) ? 1023 : 1;
                batt = ($urandom_range(99) < 80) ? $urandom_range(1023, 600)
                                                 : $urandom_range(1023);
                push_sample(($urandom_range(99) < 12) ? 1'b0 : 1'b1, bg, batt);
            end
        end
        while (done_total != queued_total)
            @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
        if (reading_q.size() != 0) begin
            $error("%0d expected results never arrived", reading_q.size());
            fail_cnt++;
        end
        $display("Checked %0d results over %0d register settings (%0d initialize beats).",
                 done_total, PHASES, init_beats);
        $display("Range flag raised on %0d results; %0d mismatches.", err_beats, fail_cnt);
        if (fail_cnt == 0)
            $display("tb_battery_voltage_monitor_core: PASS");
        else
            $display("tb_battery_voltage_monitor_core: FAIL");
        $finish;
    end

    initial begin
        #12_000_000;
        $display("tb_battery_voltage_monitor_core: FAIL");
        $finish;
    end

endmodule
